[rtl/core/vector_rotate_axis_angle_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the axis-angle rotation block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VECTOR_ROTATE_AXIS_ANGLE_ASSERT_SVH
`define VECTOR_ROTATE_AXIS_ANGLE_ASSERT_SVH

// same-cycle implication
`define VRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/vra_pkg.sv]
// ----------------------------------------------------------------------------
// vra_pkg
// Widths, latencies, constants and helpers of the axis-angle rotation block.
// ----------------------------------------------------------------------------
package vra_pkg;

  localparam int COMP_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ANGLE_BITS = FRAC_BITS + 4;
  localparam int IQ         = 30;
  localparam int AXM_BITS   = IQ;

  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 31;
  localparam int CORDIC_STEPS = 30;

  localparam int SQRT_LAT   = SQRT_STEPS + 1;
  localparam int DIV_LAT    = DIV_STEPS;
  localparam int CORDIC_LAT = CORDIC_STEPS + 1;

  localparam int AX_DLY     = SQRT_LAT;
  localparam int CS_DLY     = SQRT_LAT + DIV_LAT - CORDIC_LAT;
  localparam int VEC_DLY    = SQRT_LAT + DIV_LAT + 4;
  localparam int PIPE_DEPTH = VEC_DLY + 1;

  typedef logic signed [COMP_BITS-1:0] comp_t;
  typedef logic signed [33:0]          mq_t;
  typedef logic signed [35:0]          mqr_t;
  typedef logic signed [34:0]          mat_t;
  typedef logic signed [35:0]          ang_t;
  typedef logic signed [33:0]          cxy_t;

  localparam ang_t PI_Q      = 36'sd3373259426;
  localparam ang_t TWO_PI_Q  = 36'sd6746518852;
  localparam ang_t HALF_PI_Q = 36'sd1686629713;
  localparam cxy_t GAIN_Q    = 34'sd652032874;
  localparam cxy_t ONE_Q     = 34'sd1073741824;

  typedef struct packed {
    logic neg;
    logic zero;
  } div_ctl_t;

  // round-half-up Q.30 product
  function automatic mqr_t mulq(input mq_t a, input mq_t b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b);
    p = p + 68'sd536870912;
    return mqr_t'(p >>> IQ);
  endfunction

  function automatic ang_t atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  return 36'sd843314857;
      5'd1:  return 36'sd497837830;
      5'd2:  return 36'sd263043837;
      5'd3:  return 36'sd133525159;
      5'd4:  return 36'sd67021687;
      5'd5:  return 36'sd33543516;
      5'd6:  return 36'sd16775851;
      5'd7:  return 36'sd8388437;
      5'd8:  return 36'sd4194283;
      5'd9:  return 36'sd2097149;
      default: return ang_t'(36'sd1 <<< (30 - 32'(i)));
    endcase
  endfunction

endpackage

[rtl/core/vra_if.sv]
// ----------------------------------------------------------------------------
// vra_in_if / vra_out_if
// Valid/ready request channels of the axis-angle rotation block.
// ----------------------------------------------------------------------------
interface vra_in_if;
  import vra_pkg::*;
  logic                         valid;
  logic                         ready;
  comp_t                        vec_x;
  comp_t                        vec_y;
  comp_t                        vec_z;
  comp_t                        axis_x;
  comp_t                        axis_y;
  comp_t                        axis_z;
  logic signed [ANGLE_BITS-1:0] angle;

  modport source(output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
                 input ready);
  modport sink(input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
               output ready);
endinterface

interface vra_out_if;
  import vra_pkg::*;
  logic  valid;
  logic  ready;
  comp_t rot_x;
  comp_t rot_y;
  comp_t rot_z;
  logic  saturated;

  modport source(output valid, rot_x, rot_y, rot_z, saturated, input ready);
  modport sink(input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

[rtl/core/vector_rotate_axis_angle.sv]
// ----------------------------------------------------------------------------
// vector_rotate_axis_angle
// Rodrigues rotation of a Q15.16 vector about an arbitrary axis.
//
//   channel   dir  payload                                     handshake
//   in_ch     in   vec_x/y/z, axis_x/y/z, angle                valid/ready
//   out_ch    out  rot_x/y/z, saturated                        valid/ready
//
// One request per cycle while the output is not held; the latency is set by the square-root
// and divider pipelines on the axis path plus the matrix stages.
// Reset (synchronous, rst_n low) clears only the valid pipe and output valid.
// The whole pipe advances when the output register is empty or being taken;
// a held output stalls every stage, including in_ch.ready.
// ----------------------------------------------------------------------------
`include "vector_rotate_axis_angle_assert.svh"

module vector_rotate_axis_angle (
  input  logic        clk,
  input  logic        rst_n,
  vra_in_if.sink      in_ch,
  vra_out_if.source   out_ch
);
  import vra_pkg::*;

  typedef struct packed {
    logic [2:0][AXM_BITS-1:0] mag;
    logic [2:0]               neg;
    logic                     zero;
  } axis_t;

  typedef struct packed {
    comp_t c;
    comp_t s;
  } cs_t;

  localparam comp_t MAX_C = comp_t'((64'sd1 <<< (COMP_BITS - 1)) - 64'sd1);
  localparam comp_t MIN_C = comp_t'(-(64'sd1 <<< (COMP_BITS - 1)));

  logic en;
  logic vld_r [PIPE_DEPTH];
  logic out_valid_r;

  // front stage
  comp_t               ax_raw [3];
  logic [COMP_BITS-1:0] ax_mag [3];
  logic [COMP_BITS-1:0] mmax;
  logic [5:0]           len;
  axis_t                fax_nxt, fax_r;
  ang_t                 th;
  ang_t                 fth_nxt, fth_r;
  logic                 fflip_nxt, fflip_r;

  axis_t axd_r  [AX_DLY];
  cs_t   csd_r  [CS_DLY];
  comp_t vecd_r [VEC_DLY][3];

  logic [31:0] root;
  comp_t       u [3];
  comp_t       cos_w, sin_w;

  mqr_t p00_r, p01_r, p02_r, p11_r, p12_r, p22_r;
  mqr_t us0_r, us1_r, us2_r, us0b_r, us1b_r, us2b_r;
  mqr_t q00_r, q01_r, q02_r, q11_r, q12_r, q22_r;
  mq_t  h1_r;
  comp_t c1_r, c2_r;
  mat_t mat_r [3][3];

  comp_t rot_w [3];
  logic  sat_w [3];
  comp_t rot_r [3];
  logic  sat_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    ax_raw[0] = in_ch.axis_x;
    ax_raw[1] = in_ch.axis_y;
    ax_raw[2] = in_ch.axis_z;
    mmax = '0;
    for (int i = 0; i < 3; i++) begin
      fax_nxt.neg[i] = ax_raw[i][COMP_BITS-1];
      ax_mag[i] = fax_nxt.neg[i] ? (~ax_raw[i] + 1'b1) : ax_raw[i];
      if (ax_mag[i] > mmax) mmax = ax_mag[i];
    end
    len = '0;
    for (int i = 0; i < COMP_BITS; i++) begin
      if (mmax[i]) len = 6'(i + 1);
    end
    fax_nxt.zero = (mmax == '0);
    // scale so the largest magnitude sits just below 2^30
    for (int i = 0; i < 3; i++) begin
      if (len > 6'(IQ)) fax_nxt.mag[i] = AXM_BITS'(ax_mag[i] >> (len - 6'(IQ)));
      else fax_nxt.mag[i] = AXM_BITS'(ax_mag[i] << (6'(IQ) - len));
    end

    th = ang_t'(in_ch.angle) <<< (IQ - FRAC_BITS);
    if (th > PI_Q) th = th - TWO_PI_Q;
    if (th < -PI_Q) th = th + TWO_PI_Q;
    fflip_nxt = 1'b0;
    fth_nxt   = th;
    if (th > HALF_PI_Q) begin
      fth_nxt   = th - PI_Q;
      fflip_nxt = 1'b1;
    end else if (th < -HALF_PI_Q) begin
      fth_nxt   = th + PI_Q;
      fflip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fax_r   <= fax_nxt;
      fth_r   <= fth_nxt;
      fflip_r <= fflip_nxt;
      axd_r[0]  <= fax_r;
      vecd_r[0][0] <= in_ch.vec_x;
      vecd_r[0][1] <= in_ch.vec_y;
      vecd_r[0][2] <= in_ch.vec_z;
      csd_r[0] <= '{c: cos_w, s: sin_w};
      for (int k = 1; k < AX_DLY; k++) axd_r[k] <= axd_r[k-1];
      for (int k = 1; k < CS_DLY; k++) csd_r[k] <= csd_r[k-1];
      for (int k = 1; k < VEC_DLY; k++) vecd_r[k] <= vecd_r[k-1];
    end
  end

  vra_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .mag_i  (fax_r.mag),
    .root_o (root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane_u
    vra_div u_div (
      .clk    (clk),
      .en     (en),
      .mag_i  (axd_r[AX_DLY-1].mag[i]),
      .root_i (root),
      .ctl_i  ('{neg: axd_r[AX_DLY-1].neg[i], zero: axd_r[AX_DLY-1].zero}),
      .u_o    (u[i])
    );
  end

  vra_cordic u_cordic (
    .clk     (clk),
    .en      (en),
    .theta_i (fth_r),
    .flip_i  (fflip_r),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  // matrix: u*u^T, u*s, then (1-c) scaling, then sums
  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= mulq(mq_t'(u[0]), mq_t'(u[0]));
      p01_r <= mulq(mq_t'(u[0]), mq_t'(u[1]));
      p02_r <= mulq(mq_t'(u[0]), mq_t'(u[2]));
      p11_r <= mulq(mq_t'(u[1]), mq_t'(u[1]));
      p12_r <= mulq(mq_t'(u[1]), mq_t'(u[2]));
      p22_r <= mulq(mq_t'(u[2]), mq_t'(u[2]));
      us0_r <= mulq(mq_t'(u[0]), mq_t'(csd_r[CS_DLY-1].s));
      us1_r <= mulq(mq_t'(u[1]), mq_t'(csd_r[CS_DLY-1].s));
      us2_r <= mulq(mq_t'(u[2]), mq_t'(csd_r[CS_DLY-1].s));
      c1_r  <= csd_r[CS_DLY-1].c;
      h1_r  <= ONE_Q - mq_t'(csd_r[CS_DLY-1].c);

      q00_r  <= mulq(mq_t'(p00_r), h1_r);
      q01_r  <= mulq(mq_t'(p01_r), h1_r);
      q02_r  <= mulq(mq_t'(p02_r), h1_r);
      q11_r  <= mulq(mq_t'(p11_r), h1_r);
      q12_r  <= mulq(mq_t'(p12_r), h1_r);
      q22_r  <= mulq(mq_t'(p22_r), h1_r);
      us0b_r <= us0_r;
      us1b_r <= us1_r;
      us2b_r <= us2_r;
      c2_r   <= c1_r;

      mat_r[0][0] <= mat_t'(q00_r + mqr_t'(c2_r));
      mat_r[0][1] <= mat_t'(q01_r - us2b_r);
      mat_r[0][2] <= mat_t'(q02_r + us1b_r);
      mat_r[1][0] <= mat_t'(q01_r + us2b_r);
      mat_r[1][1] <= mat_t'(q11_r + mqr_t'(c2_r));
      mat_r[1][2] <= mat_t'(q12_r - us0b_r);
      mat_r[2][0] <= mat_t'(q02_r - us1b_r);
      mat_r[2][1] <= mat_t'(q12_r + us0b_r);
      mat_r[2][2] <= mat_t'(q22_r + mqr_t'(c2_r));
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane_row
    vra_row u_row (
      .clk   (clk),
      .en    (en),
      .row_i (mat_r[i]),
      .vec_i (vecd_r[VEC_DLY-1]),
      .rot_o (rot_w[i]),
      .sat_o (sat_w[i])
    );
  end

  // merge lanes into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) rot_r[i] <= rot_w[i];
      sat_r <= sat_w[0] | sat_w[1] | sat_w[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_DEPTH; k++) vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int k = 1; k < PIPE_DEPTH; k++) vld_r[k] <= vld_r[k-1];
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.rot_x     = rot_r[0];
  assign out_ch.rot_y     = rot_r[1];
  assign out_ch.rot_z     = rot_r[2];
  assign out_ch.saturated = sat_r;

  `VRA_ASSERT_NXT(a_req_enters, in_ch.valid && in_ch.ready, vld_r[0], "accepted request lost at pipe entry")
  `VRA_ASSERT_IMP(a_out_from_pipe, $rose(out_valid_r), $past(vld_r[PIPE_DEPTH-1]), "result without request")
  `VRA_ASSERT_IMP(a_sat_limit, out_valid_r && sat_r, rot_r[0] == MAX_C || rot_r[0] == MIN_C || rot_r[1] == MAX_C || rot_r[1] == MIN_C || rot_r[2] == MAX_C || rot_r[2] == MIN_C, "saturated flag without clipped component")

endmodule

[rtl/core/vra_sqrt.sv]
// ----------------------------------------------------------------------------
// vra_sqrt
// Sum of squares of the scaled axis and a pipelined integer square root,
// one result bit per stage.
// ----------------------------------------------------------------------------
module vra_sqrt (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [2:0][vra_pkg::AXM_BITS-1:0]     mag_i,
  output logic [31:0]                           root_o
);
  import vra_pkg::*;

  logic [63:0] sum_r;
  logic [63:0] v_r   [SQRT_STEPS];
  logic [63:0] res_r [SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= 64'(mag_i[0]) * 64'(mag_i[0]) + 64'(mag_i[1]) * 64'(mag_i[1])
             + 64'(mag_i[2]) * 64'(mag_i[2]);
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STEPS - 1 - k));
    logic [63:0] v_in, res_in, trial, v_nxt, res_nxt;
    always_comb begin
      if (k == 0) begin
        v_in   = sum_r;
        res_in = '0;
      end else begin
        v_in   = v_r[k-1];
        res_in = res_r[k-1];
      end
      trial = res_in + BIT;
      if (v_in >= trial) begin
        v_nxt   = v_in - trial;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        v_nxt   = v_in;
        res_nxt = res_in >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k]   <= v_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign root_o = res_r[SQRT_STEPS-1][31:0];

endmodule

[rtl/core/vra_div.sv]
// ----------------------------------------------------------------------------
// vra_div
// One axis lane: rounded (mag * 2^30) / root by restoring division,
// one quotient bit per stage, then the axis sign.
// ----------------------------------------------------------------------------
module vra_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [vra_pkg::AXM_BITS-1:0]  mag_i,
  input  logic [31:0]                   root_i,
  input  vra_pkg::div_ctl_t             ctl_i,
  output vra_pkg::comp_t                u_o
);
  import vra_pkg::*;

  logic [60:0]          dividend;
  logic [31:0]          rem_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] q_r   [DIV_STEPS];
  logic [30:0]          dlo_r [DIV_STEPS];
  logic [31:0]          den_r [DIV_STEPS];
  div_ctl_t             ctl_r [DIV_STEPS];

  assign dividend = {1'b0, mag_i, 30'd0} + 61'(root_i >> 1);

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [31:0]          rem_in, den_in, rem_nxt;
    logic [DIV_STEPS-1:0] q_in;
    logic [30:0]          dlo_in;
    div_ctl_t             ctl_in;
    logic [32:0]          t;
    logic                 ge;
    always_comb begin
      if (j == 0) begin
        rem_in = 32'(dividend[60:31]);
        dlo_in = dividend[30:0];
        q_in   = '0;
        den_in = root_i;
        ctl_in = ctl_i;
      end else begin
        rem_in = rem_r[j-1];
        dlo_in = dlo_r[j-1];
        q_in   = q_r[j-1];
        den_in = den_r[j-1];
        ctl_in = ctl_r[j-1];
      end
      t  = {rem_in, dlo_in[30]};
      ge = (t >= {1'b0, den_in});
      rem_nxt = ge ? 32'(t - {1'b0, den_in}) : t[31:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        q_r[j]   <= {q_in[DIV_STEPS-2:0], ge};
        dlo_r[j] <= {dlo_in[29:0], 1'b0};
        den_r[j] <= den_in;
        ctl_r[j] <= ctl_in;
      end
    end
  end

  always_comb begin
    if (ctl_r[DIV_STEPS-1].zero) begin
      u_o = '0;
    end else if (ctl_r[DIV_STEPS-1].neg) begin
      u_o = comp_t'(-$signed({1'b0, q_r[DIV_STEPS-1]}));
    end else begin
      u_o = comp_t'($signed({1'b0, q_r[DIV_STEPS-1]}));
    end
  end

endmodule

[rtl/core/vra_cordic.sv]
// ----------------------------------------------------------------------------
// vra_cordic
// Pipelined rotation-mode CORDIC giving cos and sin of the reduced angle,
// with half-turn correction and clipping to plus or minus one.
// ----------------------------------------------------------------------------
module vra_cordic (
  input  logic            clk,
  input  logic            en,
  input  vra_pkg::ang_t   theta_i,
  input  logic            flip_i,
  output vra_pkg::comp_t  cos_o,
  output vra_pkg::comp_t  sin_o
);
  import vra_pkg::*;

  cxy_t  x_r [CORDIC_STEPS];
  cxy_t  y_r [CORDIC_STEPS];
  ang_t  z_r [CORDIC_STEPS];
  logic  f_r [CORDIC_STEPS];
  comp_t cos_r, sin_r;
  cxy_t  xf, yf;
  comp_t cos_nxt, sin_nxt;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cxy_t x_in, y_in, dx, dy, x_nxt, y_nxt;
    ang_t z_in, z_nxt;
    logic f_in;
    always_comb begin
      if (i == 0) begin
        x_in = GAIN_Q;
        y_in = '0;
        z_in = theta_i;
        f_in = flip_i;
      end else begin
        x_in = x_r[i-1];
        y_in = y_r[i-1];
        z_in = z_r[i-1];
        f_in = f_r[i-1];
      end
      dx = y_in >>> i;
      dy = x_in >>> i;
      if (!z_in[35]) begin
        x_nxt = x_in - dx;
        y_nxt = y_in + dy;
        z_nxt = z_in - atan_q30(5'(i));
      end else begin
        x_nxt = x_in + dx;
        y_nxt = y_in - dy;
        z_nxt = z_in + atan_q30(5'(i));
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
        f_r[i] <= f_in;
      end
    end
  end

  always_comb begin
    xf = f_r[CORDIC_STEPS-1] ? -x_r[CORDIC_STEPS-1] : x_r[CORDIC_STEPS-1];
    yf = f_r[CORDIC_STEPS-1] ? -y_r[CORDIC_STEPS-1] : y_r[CORDIC_STEPS-1];
    if (xf > ONE_Q) cos_nxt = comp_t'(ONE_Q);
    else if (xf < -ONE_Q) cos_nxt = comp_t'(-ONE_Q);
    else cos_nxt = comp_t'(xf);
    if (yf > ONE_Q) sin_nxt = comp_t'(ONE_Q);
    else if (yf < -ONE_Q) sin_nxt = comp_t'(-ONE_Q);
    else sin_nxt = comp_t'(yf);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

[rtl/core/vra_row.sv]
// ----------------------------------------------------------------------------
// vra_row
// One output lane: row of the rotation matrix times the vector,
// rounded back to the component format and saturated.
// ----------------------------------------------------------------------------
module vra_row (
  input  logic            clk,
  input  logic            en,
  input  vra_pkg::mat_t   row_i [3],
  input  vra_pkg::comp_t  vec_i [3],
  output vra_pkg::comp_t  rot_o,
  output logic            sat_o
);
  import vra_pkg::*;

  localparam logic signed [36:0] MAXV = 37'((64'sd1 <<< (COMP_BITS - 1)) - 64'sd1);
  localparam logic signed [36:0] MINV = 37'(-(64'sd1 <<< (COMP_BITS - 1)));

  logic [63:0]        prod_r [3];
  logic               sgn_r  [3];
  logic signed [66:0] acc;
  logic signed [36:0] sh;

  for (genvar j = 0; j < 3; j++) begin : g_mul
    logic              vneg, kneg;
    logic [31:0]       vmag, kmag;
    mat_t              kabs;
    always_comb begin
      vneg = vec_i[j][COMP_BITS-1];
      vmag = vneg ? 32'(-vec_i[j]) : 32'(vec_i[j]);
      kneg = row_i[j][34];
      kabs = kneg ? -row_i[j] : row_i[j];
      kmag = kabs[31:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[j] <= 64'(vmag) * 64'(kmag);
        sgn_r[j]  <= vneg ^ kneg;
      end
    end
  end

  always_comb begin
    acc = 67'sd536870912;
    for (int j = 0; j < 3; j++) begin
      if (sgn_r[j]) acc = acc - $signed({3'b000, prod_r[j]});
      else acc = acc + $signed({3'b000, prod_r[j]});
    end
    sh = 37'(acc >>> IQ);
    if (sh > MAXV) begin
      rot_o = comp_t'(MAXV);
      sat_o = 1'b1;
    end else if (sh < MINV) begin
      rot_o = comp_t'(MINV);
      sat_o = 1'b1;
    end else begin
      rot_o = comp_t'(sh);
      sat_o = 1'b0;
    end
  end

endmodule
